[rtl/core/three_layer_dense_relu_engine_unit_defines.svh]
// Assertion macros used by the dense engine top level.
`ifndef THREE_LAYER_DENSE_RELU_ENGINE_UNIT_DEFINES_SVH
`define THREE_LAYER_DENSE_RELU_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define TDRE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define TDRE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tdre_pkg.sv]
// Shared types, constants and helpers of the dense engine.
package tdre_pkg;

    // Parameter defaults
    localparam int INPUT_DEPTH_DEF  = 8192;
    localparam int HIDDEN_DEPTH_DEF = 512;
    localparam int LAYER_COUNT_DEF  = 3;

    // Field widths
    localparam int REQ_W        = 2;
    localparam int VALUE_W      = 16;
    localparam int LAYER_W      = 2;
    localparam int NEURON_IDX_W = 9;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = 32;
    localparam int Q_W          = 41;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 32;

    // Configuration registers
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam int FIRST_IN_W = 14;
    localparam int OUTS_W     = 10;

    localparam logic [FIRST_IN_W-1:0] FIRST_INPUTS_RST   = 14'd7680;
    localparam logic [OUTS_W-1:0]     FIRST_OUTPUTS_RST  = 10'd512;
    localparam logic [OUTS_W-1:0]     SECOND_OUTPUTS_RST = 10'd512;
    localparam logic [OUTS_W-1:0]     FINAL_OUTPUTS_RST  = 10'd6;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FIRST_INPUTS   = 2'd0,
        CFG_FIRST_OUTPUTS  = 2'd1,
        CFG_SECOND_OUTPUTS = 2'd2,
        CFG_FINAL_OUTPUTS  = 2'd3
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_WEIGHT = 2'd1,
        REQ_BIAS   = 2'd2,
        REQ_RSVD   = 2'd3
    } t_req;

    // Controller -> datapath
    typedef struct packed {
        logic load;      // write activation, bump load count
        logic take_val;  // capture weight or bias
        logic fetch;     // read activation buffers
        logic mul;       // weight x activation
        logic acc;       // accumulate, bump product count
        logic round;     // add bias, round to Q8.8
        logic clip;      // ReLU, saturate, write back, advance counters
        logic err;       // stage an order-error result
        logic emit;      // move staged result to output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic load_ok;
        logic weight_ok;
        logic bias_ok;
        logic out_free;
    } t_status;

    // Layer size clamp to [1, hi]
    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        int unsigned r;
        r = v;
        if (v < 1) r = 1;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage

[rtl/core/tdre_ctrl.sv]
// Sequencing state machine of the dense engine.
module tdre_ctrl
    import tdre_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_req    i_req,
    input  t_status i_sts,
    output logic    o_ready,
    output t_cmd    o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FETCH = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_ACC   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_CLIP  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_req)
                        REQ_LOAD: begin
                            if (i_sts.load_ok) begin
                                o_cmd.load = 1'b1;
                            end else begin
                                o_cmd.err = 1'b1;
                                n_state   = ST_EMIT;
                            end
                        end
                        REQ_WEIGHT: begin
                            if (i_sts.weight_ok) begin
                                o_cmd.take_val = 1'b1;
                                n_state        = ST_FETCH;
                            end else begin
                                o_cmd.err = 1'b1;
                                n_state   = ST_EMIT;
                            end
                        end
                        REQ_BIAS: begin
                            if (i_sts.bias_ok) begin
                                o_cmd.take_val = 1'b1;
                                n_state        = ST_ROUND;
                            end else begin
                                o_cmd.err = 1'b1;
                                n_state   = ST_EMIT;
                            end
                        end
                        default: ;  // reserved code: dropped silently
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = ST_CLIP;
            end
            ST_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

[rtl/core/tdre_datapath.sv]
// Buffers, counters, MAC and result registers of the dense engine.
module tdre_datapath
    import tdre_pkg::*;
#(
    parameter int INPUT_DEPTH  = INPUT_DEPTH_DEF,
    parameter int HIDDEN_DEPTH = HIDDEN_DEPTH_DEF,
    parameter int LAYER_COUNT  = LAYER_COUNT_DEF,
    localparam int LCW = $clog2(INPUT_DEPTH + 1),
    localparam int NCW = $clog2(HIDDEN_DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_sts,
    input  logic [VALUE_W-1:0]       i_value,
    input  logic [LCW-1:0]           i_nin0,
    input  logic [NCW-1:0]           i_nout0,
    input  logic [NCW-1:0]           i_nout1,
    input  logic [NCW-1:0]           i_nout_final,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [LAYER_W-1:0]       o_layer,
    output logic [NEURON_IDX_W-1:0]  o_neuron,
    output logic [VALUE_W-1:0]       o_value,
    output logic                     o_sat,
    output logic                     o_err,
    output logic                     o_last
);

    localparam int IW  = $clog2(INPUT_DEPTH);
    localparam int HW  = $clog2(HIDDEN_DEPTH);
    localparam int PCW = (LCW > NCW) ? LCW : NCW;
    localparam logic [LAYER_W-1:0] FINAL_LAYER = LAYER_W'(LAYER_COUNT - 1);

    // Activation buffers
    logic [VALUE_W-1:0] r_input_store [INPUT_DEPTH];
    logic [VALUE_W-1:0] r_hidden_one  [HIDDEN_DEPTH];
    logic [VALUE_W-1:0] r_hidden_two  [HIDDEN_DEPTH];

    // Control state
    logic [LCW-1:0]     r_load_cnt;
    logic [LAYER_W-1:0] r_layer;
    logic [NCW-1:0]     r_nc;
    logic [PCW-1:0]     r_pc;
    logic [ACC_W-1:0]   r_acc;
    logic               r_out_valid;

    // Payload
    logic signed [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0]        r_act0;
    logic [VALUE_W-1:0]        r_act1;
    logic [VALUE_W-1:0]        r_act2;
    logic signed [PROD_W-1:0]  r_prod;
    logic [Q_W-1:0]            r_q;

    logic [LAYER_W-1:0]      r_p_layer;
    logic [NEURON_IDX_W-1:0] r_p_neuron;
    logic [VALUE_W-1:0]      r_p_value;
    logic                    r_p_sat;
    logic                    r_p_err;
    logic                    r_p_last;

    logic [LAYER_W-1:0]      r_o_layer;
    logic [NEURON_IDX_W-1:0] r_o_neuron;
    logic [VALUE_W-1:0]      r_o_value;
    logic                    r_o_sat;
    logic                    r_o_err;
    logic                    r_o_last;

    logic [PCW-1:0]            w_nin;
    logic [NCW-1:0]            w_nout;
    logic                      w_loaded;
    logic                      w_final;
    logic signed [VALUE_W-1:0] w_act;
    logic [ACC_W:0]            w_sum;
    logic [Q_W-1:0]            w_relu;
    logic                      w_over;
    logic                      w_under;
    logic [VALUE_W-1:0]        w_clip;
    logic [NCW-1:0]            w_nc_inc;
    logic                      w_layer_done;
    logic [NEURON_IDX_W-1:0]   w_neuron;

    assign w_final  = (r_layer == FINAL_LAYER);
    assign w_loaded = (r_load_cnt >= i_nin0);
    assign w_neuron = NEURON_IDX_W'(32'(r_nc));

    always_comb begin
        if (r_layer == '0)          w_nin = PCW'(i_nin0);
        else if (r_layer == 2'd1)   w_nin = PCW'(i_nout0);
        else                        w_nin = PCW'(i_nout1);
        if (w_final)                w_nout = i_nout_final;
        else if (r_layer == '0)     w_nout = i_nout0;
        else                        w_nout = i_nout1;
    end

    always_comb begin
        if (r_layer == '0)          w_act = $signed(r_act0);
        else if (r_layer == 2'd1)   w_act = $signed(r_act1);
        else                        w_act = $signed(r_act2);
    end

    // acc + bias*256 + 128, 49 bits
    assign w_sum = {r_acc[ACC_W-1], r_acc}
                 + {{25{r_val[VALUE_W-1]}}, r_val, 8'h80};

    assign w_relu  = (!w_final && r_q[Q_W-1]) ? '0 : r_q;
    assign w_over  = !w_relu[Q_W-1] && (|w_relu[Q_W-2:VALUE_W-1]);
    assign w_under = w_relu[Q_W-1] && !(&w_relu[Q_W-2:VALUE_W-1]);
    assign w_clip  = w_over  ? 16'h7FFF :
                     w_under ? 16'h8000 : w_relu[VALUE_W-1:0];

    assign w_nc_inc     = NCW'(r_nc + 1'b1);
    assign w_layer_done = (w_nc_inc >= w_nout);

    assign o_sts.load_ok   = (r_layer == '0) && (r_nc == '0) && (r_pc == '0) && !w_loaded;
    assign o_sts.weight_ok = w_loaded && (r_pc < w_nin);
    assign o_sts.bias_ok   = w_loaded && (r_pc >= w_nin);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Buffers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_input_store[r_load_cnt[IW-1:0]] <= i_value;
        end
        if (i_cmd.clip && (r_layer == '0)) begin
            r_hidden_one[r_nc[HW-1:0]] <= w_clip;
        end
        if (i_cmd.clip && (r_layer == 2'd1)) begin
            r_hidden_two[r_nc[HW-1:0]] <= w_clip;
        end
        if (i_cmd.fetch) begin
            r_act0 <= r_input_store[r_pc[IW-1:0]];
            r_act1 <= r_hidden_one[r_pc[HW-1:0]];
            r_act2 <= r_hidden_two[r_pc[HW-1:0]];
        end
    end

    // Counters and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_layer    <= '0;
            r_nc       <= '0;
            r_pc       <= '0;
            r_acc      <= '0;
        end else begin
            if (i_cmd.load) begin
                r_load_cnt <= LCW'(r_load_cnt + 1'b1);
            end
            if (i_cmd.acc) begin
                r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
                r_pc  <= PCW'(r_pc + 1'b1);
            end
            if (i_cmd.clip) begin
                r_pc  <= '0;
                r_acc <= '0;
                if (w_layer_done) begin
                    r_nc <= '0;
                    if (w_final) begin
                        r_layer    <= '0;
                        r_load_cnt <= '0;
                    end else begin
                        r_layer <= LAYER_W'(r_layer + 1'b1);
                    end
                end else begin
                    r_nc <= w_nc_inc;
                end
            end
        end
    end

    // Arithmetic pipeline and staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_val) r_val  <= $signed(i_value);
        if (i_cmd.mul)      r_prod <= PROD_W'(r_val * w_act);
        if (i_cmd.round)    r_q    <= w_sum[ACC_W:8];
        if (i_cmd.clip) begin
            r_p_layer  <= r_layer;
            r_p_neuron <= w_neuron;
            r_p_value  <= w_clip;
            r_p_sat    <= w_over || w_under;
            r_p_err    <= 1'b0;
            r_p_last   <= w_layer_done && w_final;
        end else if (i_cmd.err) begin
            r_p_layer  <= r_layer;
            r_p_neuron <= w_neuron;
            r_p_value  <= '0;
            r_p_sat    <= 1'b0;
            r_p_err    <= 1'b1;
            r_p_last   <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_layer  <= r_p_layer;
            r_o_neuron <= r_p_neuron;
            r_o_value  <= r_p_value;
            r_o_sat    <= r_p_sat;
            r_o_err    <= r_p_err;
            r_o_last   <= r_p_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_layer     = r_o_layer;
    assign o_neuron    = r_o_neuron;
    assign o_value     = r_o_value;
    assign o_sat       = r_o_sat;
    assign o_err       = r_o_err;
    assign o_last      = r_o_last;

endmodule

[rtl/core/three_layer_dense_relu_engine_unit.sv]
// Top level of the three-layer dense ReLU engine: config registers, controller, datapath.
//
//  Channel      | Dir | Transaction carries
//  -------------+-----+----------------------------------------------------------
//  s_axis       | in  | tuser: req_type[1:0]; tdata: value[15:0] (signed Q8.8)
//  m_axis       | out | tdata: layer, neuron, value, saturated; tuser: order_error;
//               |     | tlast: final neuron of final layer
//  cfg          | in  | write-only: we, addr (register index), wdata[13:0]
//
//  Steps per transaction: activation load, accept only; weight: accept, registered buffer
//  read, multiply, accumulate; bias: accept, round, ReLU/saturate/write-back,
//  hand-off; order error: accept, hand-off. Reset is synchronous, active low,
//  and clears config, counters, accumulator and output valid; buffers are not cleared.
//  The output register lets one result wait while a new item is taken; the next
//  result then stalls in hand-off, and the input with it, until the receiver reads.
`include "three_layer_dense_relu_engine_unit_defines.svh"

module three_layer_dense_relu_engine_unit
    import tdre_pkg::*;
#(
    parameter int INPUT_DEPTH  = INPUT_DEPTH_DEF,
    parameter int HIDDEN_DEPTH = HIDDEN_DEPTH_DEF,
    parameter int LAYER_COUNT  = LAYER_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [15:0] value
    input  logic [REQ_W-1:0]       i_s_axis_tuser,   // [1:0] req_type
    // master stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [1:0] layer_index, [10:2] neuron_index,
                                                     // [26:11] neuron_value, [27] saturated
    output logic                   o_m_axis_tuser,   // [0] order_error
    output logic                   o_m_axis_tlast,   // last
    // configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int LCW = $clog2(INPUT_DEPTH + 1);
    localparam int NCW = $clog2(HIDDEN_DEPTH + 1);

    // Layer size registers
    logic [FIRST_IN_W-1:0] r_first_inputs;
    logic [OUTS_W-1:0]     r_first_outputs;
    logic [OUTS_W-1:0]     r_second_outputs;
    logic [OUTS_W-1:0]     r_final_outputs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_inputs   <= FIRST_INPUTS_RST;
            r_first_outputs  <= FIRST_OUTPUTS_RST;
            r_second_outputs <= SECOND_OUTPUTS_RST;
            r_final_outputs  <= FINAL_OUTPUTS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_FIRST_INPUTS:   r_first_inputs   <= i_cfg_wdata[FIRST_IN_W-1:0];
                CFG_FIRST_OUTPUTS:  r_first_outputs  <= i_cfg_wdata[OUTS_W-1:0];
                CFG_SECOND_OUTPUTS: r_second_outputs <= i_cfg_wdata[OUTS_W-1:0];
                CFG_FINAL_OUTPUTS:  r_final_outputs  <= i_cfg_wdata[OUTS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes clamped to [1, buffer depth]; out-of-range settings act as the bound
    logic [LCW-1:0] w_nin0;
    logic [NCW-1:0] w_nout0;
    logic [NCW-1:0] w_nout1;
    logic [NCW-1:0] w_nout_final;

    assign w_nin0       = LCW'(clamp_size(32'(r_first_inputs), INPUT_DEPTH));
    assign w_nout0      = NCW'(clamp_size(32'(r_first_outputs), HIDDEN_DEPTH));
    assign w_nout1      = NCW'(clamp_size(32'(r_second_outputs), HIDDEN_DEPTH));
    assign w_nout_final = NCW'(clamp_size(32'(r_final_outputs), HIDDEN_DEPTH));

    t_cmd    w_cmd;
    t_status w_sts;

    logic [LAYER_W-1:0]      w_layer;
    logic [NEURON_IDX_W-1:0] w_neuron;
    logic [VALUE_W-1:0]      w_value;
    logic                    w_sat;

    tdre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_req   (t_req'(i_s_axis_tuser)),
        .i_sts   (w_sts),
        .o_ready (o_s_axis_tready),
        .o_cmd   (w_cmd)
    );

    tdre_datapath #(
        .INPUT_DEPTH  (INPUT_DEPTH),
        .HIDDEN_DEPTH (HIDDEN_DEPTH),
        .LAYER_COUNT  (LAYER_COUNT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_s_axis_tdata[VALUE_W-1:0]),
        .i_nin0       (w_nin0),
        .i_nout0      (w_nout0),
        .i_nout1      (w_nout1),
        .i_nout_final (w_nout_final),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_layer      (w_layer),
        .o_neuron     (w_neuron),
        .o_value      (w_value),
        .o_sat        (w_sat),
        .o_err        (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    // Pack result fields, zero pad to 32 bits
    assign o_m_axis_tdata = {4'b0000, w_sat, w_value, w_neuron, w_layer};

    // Only one sequencing step may be active at a time
    `TDRE_ASSERT_NOW(a_one_step, i_clk, i_rst_n, 1'b1,
        $onehot0({w_cmd.load, w_cmd.fetch, w_cmd.mul, w_cmd.acc,
                  w_cmd.round, w_cmd.clip, w_cmd.emit}),
        "more than one datapath step active")

    // A buffer read is always followed by the multiply
    `TDRE_ASSERT_NEXT(a_fetch_mul, i_clk, i_rst_n, w_cmd.fetch, w_cmd.mul,
        "buffer read not followed by multiply")

    // After write-back the input side stays closed until the result is handed off
    `TDRE_ASSERT_NEXT(a_clip_hold, i_clk, i_rst_n, w_cmd.clip, !o_s_axis_tready,
        "input accepted before neuron result hand-off")

    // An error record never closes the final layer
    `TDRE_ASSERT_NOW(a_last_no_err, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast,
        !o_m_axis_tuser, "final neuron flagged as order error")

endmodule
